// ===== hw/rtl/attribute_video_pixel_generator_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the attribute video pixel generator
// Immediate-implication and next-cycle-implication checks; empty under SYNTH.
// ----------------------------------------------------------------------------
`ifndef ATTRIBUTE_VIDEO_PIXEL_GENERATOR_TOP_MACROS_SVH
`define ATTRIBUTE_VIDEO_PIXEL_GENERATOR_TOP_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define AVPG_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define AVPG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define AVPG_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define AVPG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/avpg_pkg.sv =====
// ----------------------------------------------------------------------------
// Attribute video pixel generator package
// Field widths, frame timing constants and the queued operation type.
// ----------------------------------------------------------------------------
package avpg_pkg;

  // field widths
  localparam int TS_W     = 17;
  localparam int ADDR_W   = 13;
  localparam int DATA_W   = 8;
  localparam int BORDER_W = 3;
  localparam int COL_W    = 9;
  localparam int ROW_W    = 9;
  localparam int CH_W     = 8;

  // video store layout
  localparam int STORE_SIZE = 6912;
  localparam int ATTR_BASE  = 'h1800;
  localparam int PIC_LINES  = 192;

  // frame timing
  localparam int LINE_TICKS_DEF     = 224;
  localparam int HIDDEN_LINES       = 16;
  localparam int TOP_BORDER_LINES   = 48;
  localparam int ACTIVE_TICKS       = 128;
  localparam int RIGHT_BORDER_TICKS = 24;
  localparam int RETRACE_TICKS      = 48;

  // color levels and attribute bits
  localparam logic [CH_W-1:0] DIM_LEVEL  = 8'hD8;
  localparam logic [CH_W-1:0] FULL_LEVEL = 8'hFF;
  localparam int ATTR_FLASH_BIT  = 7;
  localparam int ATTR_BRIGHT_BIT = 6;

  // request codes
  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // front-to-back queue depth
  localparam int Q_DEPTH = 4;

  typedef enum logic {
    OP_WRITE,
    OP_PIXELS
  } op_kind_t;

  // one classified operation for the back end
  typedef struct packed {
    op_kind_t              kind;
    logic                  picture;
    logic [COL_W-1:0]      col0;
    logic [ROW_W-1:0]      row;
    logic [BORDER_W-1:0]   border;
    logic                  flash;
    logic [1:0]            sel;
    logic [ADDR_W-1:0]     baddr;
    logic [ADDR_W-1:0]     aaddr;
    logic [ADDR_W-1:0]     waddr;
    logic [DATA_W-1:0]     wdata;
  } op_t;

endpackage

// ===== hw/rtl/avpg_front.sv =====
// ----------------------------------------------------------------------------
// Attribute video pixel generator front end
// Splits the T-state into line and offset, classifies the tick and builds
// store addresses; write requests pass through in order.
// ----------------------------------------------------------------------------
`include "attribute_video_pixel_generator_top_macros.svh"

module avpg_front #(
  parameter int LINE_TICKS = avpg_pkg::LINE_TICKS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            hold,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            req_type,
  input  logic [avpg_pkg::TS_W-1:0]       tstate,
  input  logic                            flash_on,
  input  logic [avpg_pkg::BORDER_W-1:0]   border_color,
  input  logic [avpg_pkg::ADDR_W-1:0]     store_address,
  input  logic [avpg_pkg::DATA_W-1:0]     store_data,
  output logic                            push_valid,
  input  logic                            push_ready,
  output avpg_pkg::op_t                   push_op
);
  import avpg_pkg::*;

  localparam int LINE_W   = $clog2(((1 << TS_W) - 1) / LINE_TICKS + 1);
  localparam int OFFS_W   = $clog2(LINE_TICKS);
  localparam int LT_W     = $clog2(LINE_TICKS + 1);
  localparam int RECIP_SH = 28;
  localparam int RECIP    = ((1 << RECIP_SH) + LINE_TICKS - 1) / LINE_TICKS;
  localparam int RECIP_W  = $clog2(RECIP + 1);
  localparam int PROD_W   = TS_W + RECIP_W + 1;
  localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
  localparam logic [LT_W-1:0]    LINE_C  = LT_W'(LINE_TICKS);

  localparam int BLANK_START = ACTIVE_TICKS + RIGHT_BORDER_TICKS;
  localparam int LEFT_START  = BLANK_START + RETRACE_TICKS;
  localparam int LEFT_TICKS  = (LINE_TICKS > LEFT_START) ? LINE_TICKS - LEFT_START : 0;
  localparam int PIC_END     = TOP_BORDER_LINES + PIC_LINES;
  localparam logic [COL_W-1:0] MAIN_BASE = COL_W'(2 * LEFT_TICKS);
  localparam logic [COL_W-1:0] WRAP_BASE = COL_W'(-2 * LEFT_START);

  typedef struct packed {
    logic                req;
    logic [TS_W-1:0]     ts;
    logic                flash;
    logic [BORDER_W-1:0] border;
    logic [ADDR_W-1:0]   addr;
    logic [DATA_W-1:0]   data;
  } fitem_t;

  fitem_t              in_item, s1, s2, s3;
  logic                s1v, s2v, s3v;
  logic                advance, accept, s3_emit;
  logic [PROD_W-1:0]   s1_prod;
  logic [LINE_W-1:0]   est_line, s2_line, s3_line, scan;
  logic [TS_W-1:0]     s2_qprod, rem;
  logic                rem_fix;
  logic [OFFS_W-1:0]   s3_offs;
  logic                hidden, retrace, wrap, picture;
  logic [7:0]          yy;
  logic [6:0]          pic_x;

  // handshake: the whole pipe stalls when the last stage cannot push
  assign advance  = !s3v || !s3_emit || push_ready;
  assign in_ready = advance && !hold;
  assign accept   = in_valid && in_ready;

  always_comb begin
    in_item.req    = req_type;
    in_item.ts     = tstate;
    in_item.flash  = flash_on;
    in_item.border = border_color;
    in_item.addr   = store_address;
    in_item.data   = store_data;
  end

  // line estimate from reciprocal product, then remainder with one correction
  assign est_line = s1_prod[RECIP_SH +: LINE_W];
  assign rem      = s2.ts - s2_qprod;
  assign rem_fix  = (rem >= TS_W'(LINE_TICKS));

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1v <= 1'b0;
      s2v <= 1'b0;
      s3v <= 1'b0;
    end else if (advance) begin
      s1v <= accept;
      s2v <= s1v;
      s3v <= s2v;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (advance) begin
      s1       <= in_item;
      s1_prod  <= PROD_W'(tstate) * PROD_W'(RECIP_C);
      s2       <= s1;
      s2_line  <= est_line;
      s2_qprod <= TS_W'(est_line) * TS_W'(LINE_C);
      s3       <= s2;
      s3_line  <= rem_fix ? s2_line + 1'b1 : s2_line;
      s3_offs  <= rem_fix ? OFFS_W'(rem - TS_W'(LINE_TICKS)) : OFFS_W'(rem);
    end
  end

  // classify the tick and build the operation
  always_comb begin
    scan    = s3_line - LINE_W'(HIDDEN_LINES);
    hidden  = (s3_line < LINE_W'(HIDDEN_LINES));
    retrace = (s3_offs >= BLANK_START) && (s3_offs < LEFT_START);
    wrap    = (s3_offs >= LEFT_START);
    picture = (s3_offs < ACTIVE_TICKS) && (scan >= TOP_BORDER_LINES) && (scan < PIC_END);
    yy      = 8'(scan - LINE_W'(TOP_BORDER_LINES));
    pic_x   = 7'(s3_offs);

    push_op.kind    = (s3.req == REQ_WRITE) ? OP_WRITE : OP_PIXELS;
    push_op.picture = picture;
    push_op.col0    = (wrap ? WRAP_BASE : MAIN_BASE) + COL_W'({s3_offs, 1'b0});
    push_op.row     = ROW_W'(scan);
    push_op.border  = s3.border;
    push_op.flash   = s3.flash;
    push_op.sel     = pic_x[1:0];
    // interleaved bitmap address: third, char row, pixel row swapped
    push_op.baddr   = {yy[7:6], yy[2:0], yy[5:3], pic_x[6:2]};
    push_op.aaddr   = ADDR_W'(ATTR_BASE) + ADDR_W'({yy[7:3], pic_x[6:2]});
    push_op.waddr   = s3.addr;
    push_op.wdata   = s3.data;

    s3_emit    = (s3.req == REQ_WRITE) || (!hidden && !retrace);
    push_valid = s3v && s3_emit;
  end

  `AVPG_ASSERT_NOW(a_front_offs_range, clk, rst, s3v && (s3.req == REQ_TICK), s3_offs < LINE_TICKS, "line offset out of range")
  `AVPG_ASSERT_NEXT(a_front_stall_hold, clk, rst, s3v && !advance, s3v && $stable(s3_offs) && $stable(s3_line), "front stage changed while stalled")

endmodule

// ===== hw/rtl/avpg_queue.sv =====
// ----------------------------------------------------------------------------
// Attribute video pixel generator operation queue
// Small FIFO of classified operations between front and back ends.
// ----------------------------------------------------------------------------
`include "attribute_video_pixel_generator_top_macros.svh"

module avpg_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  avpg_pkg::op_t  push_op,
  output logic           head_valid,
  output avpg_pkg::op_t  head_op,
  input  logic           pop
);
  import avpg_pkg::*;

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  op_t              slots [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;

  assign push_ready = (count != CNT_W'(Q_DEPTH));
  assign push       = push_valid && push_ready;
  assign head_valid = (count != '0);
  assign head_op    = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `AVPG_ASSERT_NEXT(a_q_count_up, clk, rst, push && !pop, count == $past(count) + 1'b1, "queue count did not advance on push")

endmodule

// ===== hw/rtl/avpg_back.sv =====
// ----------------------------------------------------------------------------
// Attribute video pixel generator back end
// Owns the video store: clears it after reset, applies writes, reads the
// bitmap and attribute bytes and sends two pixels per render tick.
// ----------------------------------------------------------------------------
`include "attribute_video_pixel_generator_top_macros.svh"

module avpg_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         head_valid,
  input  avpg_pkg::op_t                head_op,
  output logic                         pop,
  output logic                         clearing,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [avpg_pkg::COL_W-1:0]   column,
  output logic [avpg_pkg::ROW_W-1:0]   row,
  output logic [avpg_pkg::CH_W-1:0]    red,
  output logic [avpg_pkg::CH_W-1:0]    green,
  output logic [avpg_pkg::CH_W-1:0]    blue,
  output logic                         last_pixel
);
  import avpg_pkg::*;

  logic [DATA_W-1:0] vstore [STORE_SIZE];

  logic [ADDR_W-1:0] clr_addr;
  logic              ov, phase;
  op_t               o_op;
  logic [DATA_W-1:0] bdata, adata;

  logic              out_free, is_write, pix_load, we;
  logic [ADDR_W-1:0] waddr;
  logic [DATA_W-1:0] wdata;

  logic              fg;
  logic [2:0]        rgb;
  logic              bright;
  logic [CH_W-1:0]   lvl;

  // dispatch from the queue head
  assign out_free = !ov || (out_ready && phase);
  assign is_write = (head_op.kind == OP_WRITE);
  assign pop      = head_valid && !clearing && (is_write || out_free);
  assign pix_load = pop && !is_write;

  // single write port shared by the clearing sweep and write requests
  assign we    = clearing || (pop && is_write && (head_op.waddr < STORE_SIZE));
  assign waddr = clearing ? clr_addr : head_op.waddr;
  assign wdata = clearing ? '0 : head_op.wdata;

  // clearing sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      clearing <= 1'b1;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == ADDR_W'(STORE_SIZE - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // video store: one write, two registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      vstore[waddr] <= wdata;
    end
    if (pix_load) begin
      bdata <= vstore[head_op.baddr];
      adata <= vstore[head_op.aaddr];
    end
  end

  // output stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      ov    <= 1'b0;
      phase <= 1'b0;
    end else begin
      if (pix_load) begin
        ov    <= 1'b1;
        phase <= 1'b0;
      end else if (ov && out_ready) begin
        ov    <= !phase;
        phase <= !phase;
      end
    end
  end

  // output stage payload
  always_ff @(posedge clk) begin
    if (pix_load) begin
      o_op <= head_op;
    end
  end

  // pixel color
  always_comb begin
    fg     = bdata[~{o_op.sel, phase}] ^ (adata[ATTR_FLASH_BIT] & o_op.flash);
    rgb    = o_op.picture ? (fg ? adata[2:0] : adata[5:3]) : o_op.border;
    bright = o_op.picture & adata[ATTR_BRIGHT_BIT];
    lvl    = bright ? FULL_LEVEL : DIM_LEVEL;
  end

  assign out_valid  = ov;
  assign column     = o_op.col0 + COL_W'(phase);
  assign row        = o_op.row;
  assign red        = rgb[1] ? lvl : '0;
  assign green      = rgb[2] ? lvl : '0;
  assign blue       = rgb[0] ? lvl : '0;
  assign last_pixel = phase;

  `AVPG_ASSERT_NOW(a_back_no_pop_clear, clk, rst, clearing, !pop, "queue popped during clearing sweep")
  `AVPG_ASSERT_NEXT(a_back_second_px, clk, rst, ov && !phase && out_ready, ov && phase, "second pixel of a tick missing")

endmodule

// ===== hw/rtl/attribute_video_pixel_generator_top.sv =====
// ----------------------------------------------------------------------------
// Attribute video pixel generator
// Channel | direction | handshake             | payload
// in      | input     | in_valid / in_ready   | req_type tstate flash_on border_color
//         |           |                       | store_address store_data
// out     | output    | out_valid / out_ready | column row red green blue last_pixel
//
// After reset the 6912-byte video store is swept to zero, one byte a cycle;
// in_ready stays low until the sweep is done.
// The front pipe is three stages deep (reciprocal multiply, remainder, classify).
// A render tick with pixels holds the output register for two pixels, one
// after the other; a write uses the store write port; ticks with no pixels
// end in the front. The next pixel tick may load as the last pixel leaves.
// A four-entry queue lets the output stall while the front keeps accepting until it fills.
// ----------------------------------------------------------------------------
`include "attribute_video_pixel_generator_top_macros.svh"

module attribute_video_pixel_generator_top #(
  parameter int LINE_TICKS = avpg_pkg::LINE_TICKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          req_type,
  input  logic [avpg_pkg::TS_W-1:0]     tstate,
  input  logic                          flash_on,
  input  logic [avpg_pkg::BORDER_W-1:0] border_color,
  input  logic [avpg_pkg::ADDR_W-1:0]   store_address,
  input  logic [avpg_pkg::DATA_W-1:0]   store_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [avpg_pkg::COL_W-1:0]    column,
  output logic [avpg_pkg::ROW_W-1:0]    row,
  output logic [avpg_pkg::CH_W-1:0]     red,
  output logic [avpg_pkg::CH_W-1:0]     green,
  output logic [avpg_pkg::CH_W-1:0]     blue,
  output logic                          last_pixel
);
  import avpg_pkg::*;

  logic push_valid, push_ready, head_valid, pop, clearing;
  op_t  push_op, head_op;

  // front end: split and classify
  avpg_front #(
    .LINE_TICKS(LINE_TICKS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .hold         (clearing),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .tstate       (tstate),
    .flash_on     (flash_on),
    .border_color (border_color),
    .store_address(store_address),
    .store_data   (store_data),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_op      (push_op)
  );

  // decoupling queue
  avpg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_op   (push_op),
    .head_valid(head_valid),
    .head_op   (head_op),
    .pop       (pop)
  );

  // back end: store and pixel output
  avpg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head_op   (head_op),
    .pop       (pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .column    (column),
    .row       (row),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .last_pixel(last_pixel)
  );

endmodule
